@@ hdl/mf3_pkg.sv @@
// Shared constants for the 3x3 max filter: data widths, register indexes
// and configuration limits. No dependencies.
package mf3_pkg;

  localparam int PIX_W             = 8;
  localparam int CFG_W             = 11;
  localparam int CFG_IDX_W         = 1;
  localparam int MAX_WIDTH_DEFAULT = 1024;
  localparam int LINE_WIDTH_RESET  = 1024;
  localparam int FRAME_ROWS_RESET  = 512;
  localparam int FRAME_ROWS_MAX    = 1024;
  localparam int DIM_MIN           = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS = 1'd1;

endpackage

@@ hdl/max_filter_3x3_unit.sv @@
// Max filter 3x3 unit: grayscale dilation over a raster pixel stream, uses mf3_pkg.
// A result is registered through stage 1, stage 2 and the output register after the transfer of
// the item that completes its window (one row plus one pixel behind it).
// Throughput: one item per cycle; the line store is read on transfer and written
// back from stage 1 with forwarding; the pipeline holds while the output waits.
// Reset: counters, window and handshakes clear; the line store is not cleared.
module max_filter_3x3_unit #(
  parameter int MAX_WIDTH = mf3_pkg::MAX_WIDTH_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  // input stream
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [7:0]                   s_tdata,   // [7:0] pixel_in
  input  logic [0:0]                   s_tuser,   // [0] flush
  // output stream
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [7:0]                   m_tdata,   // [7:0] pixel_out
  output logic                         m_tlast,   // frame_end
  // configuration write port
  input  logic                         cfg_we,
  input  logic [mf3_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mf3_pkg::CFG_W-1:0]    cfg_data
);

  localparam int AW     = $clog2(MAX_WIDTH);
  localparam int PW     = ((AW > mf3_pkg::CFG_W) ? AW : mf3_pkg::CFG_W) + 2;
  localparam int LW_MAX = (MAX_WIDTH > 2047) ? 2047 : MAX_WIDTH;
  localparam int LW_RST = (mf3_pkg::LINE_WIDTH_RESET > LW_MAX) ? LW_MAX
                                                               : mf3_pkg::LINE_WIDTH_RESET;
  localparam int PIX_W  = mf3_pkg::PIX_W;
  localparam int CW     = mf3_pkg::CFG_W;

  // configuration
  logic [CW-1:0] line_width;
  logic [CW-1:0] frame_rows;

  // position counters
  logic [AW-1:0] in_column;
  logic [CW-1:0] in_row;

  // line store: upper byte is two rows back, lower byte is previous row
  logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
  logic [2*PIX_W-1:0] rd_word;
  logic               fwd;
  logic [2*PIX_W-1:0] fwd_word;

  // stage 1: read in flight
  logic             v1;
  logic [AW-1:0]    addr1;
  logic [PIX_W-1:0] pix1;
  logic             res1;
  logic             fe1;
  logic [2:0]       rmask1;
  logic [2:0]       cmask1;

  // stage 2: window updated
  logic             v2;
  logic             res2;
  logic             fe2;
  logic [2:0]       rmask2;
  logic [2:0]       cmask2;
  logic [PIX_W-1:0] win [9];

  logic             adv;
  logic             accept;
  logic [PIX_W-1:0] pix0;

  logic signed [PW-1:0] ir_s, ic_s, lw_s, fr_s, pr0, pc0;
  logic                 res0, fe0;
  logic [2:0]           rmask0, cmask0;
  logic [AW:0]          col_inc;
  logic [AW-1:0]        in_column_next;
  logic [CW-1:0]        in_row_next;

  logic [2*PIX_W-1:0] cur_word;
  logic [PIX_W-1:0]   top1, mid1;
  logic [PIX_W-1:0]   max2;

  // pipeline moves whenever the output register is free or being taken
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv && !rst;
  assign accept   = s_tvalid && s_tready;
  assign pix0     = s_tuser[0] ? '0 : s_tdata;

  // configuration writes, clamped to the legal range
  always_ff @(posedge clk) begin
    if (rst) begin
      line_width <= CW'(LW_RST);
      frame_rows <= CW'(mf3_pkg::FRAME_ROWS_RESET);
    end else if (cfg_we) begin
      unique case (cfg_index)
        mf3_pkg::REG_LINE_WIDTH: begin
          if (cfg_data < CW'(mf3_pkg::DIM_MIN))    line_width <= CW'(mf3_pkg::DIM_MIN);
          else if (cfg_data > CW'(LW_MAX))         line_width <= CW'(LW_MAX);
          else                                     line_width <= cfg_data;
        end
        mf3_pkg::REG_FRAME_ROWS: begin
          if (cfg_data < CW'(mf3_pkg::DIM_MIN))    frame_rows <= CW'(mf3_pkg::DIM_MIN);
          else if (cfg_data > CW'(mf3_pkg::FRAME_ROWS_MAX))
            frame_rows <= CW'(mf3_pkg::FRAME_ROWS_MAX);
          else                                     frame_rows <= cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  // position of the window centre that this transfer completes
  always_comb begin
    logic signed [PW-1:0] r;
    logic signed [PW-1:0] c;
    ir_s = PW'(in_row);
    ic_s = PW'(in_column);
    lw_s = PW'(line_width);
    fr_s = PW'(frame_rows);
    if (in_column != '0) begin
      pr0  = ir_s - PW'(1);
      pc0  = ic_s - PW'(1);
      res0 = (in_row != '0);
    end else begin
      pr0  = ir_s - PW'(2);
      pc0  = lw_s - PW'(1);
      res0 = (in_row >= CW'(2));
    end
    fe0 = res0 && (pr0 >= fr_s - PW'(1)) && (pc0 >= lw_s - PW'(1));
    for (int i = 0; i < 3; i++) begin
      r = pr0 + PW'(i) - PW'(1);
      c = pc0 + PW'(i) - PW'(1);
      rmask0[i] = (r >= 0) && (r < fr_s);
      cmask0[i] = (c >= 0) && (c < lw_s);
    end
  end

  // next position, wrapping at row end and restarting after the frame end
  always_comb begin
    col_inc        = {1'b0, in_column} + (AW+1)'(1);
    in_column_next = col_inc[AW-1:0];
    in_row_next    = in_row;
    if ((AW+2)'(col_inc) >= (AW+2)'(line_width) ||
        (AW+2)'(line_width) > (AW+2)'(MAX_WIDTH)) begin
      in_column_next = '0;
      if (in_row != '1) in_row_next = in_row + CW'(1);
    end
    if (fe0) begin
      in_column_next = '0;
      in_row_next    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_column <= '0;
      in_row    <= '0;
    end else if (accept) begin
      in_column <= in_column_next;
      in_row    <= in_row_next;
    end
  end

  // line store read on transfer, written back from stage 1
  always_ff @(posedge clk) begin
    if (accept) rd_word <= line_mem[in_column];
    if (adv && v1) line_mem[addr1] <= {mid1, pix1};
  end

  // same entry written while read: forward the written word
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd <= 1'b0;
    end else if (adv) begin
      fwd <= accept && v1 && (addr1 == in_column);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) fwd_word <= {mid1, pix1};
  end

  assign cur_word = fwd ? fwd_word : rd_word;
  assign top1     = cur_word[2*PIX_W-1:PIX_W];
  assign mid1     = cur_word[PIX_W-1:0];

  // stage registers
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (adv) begin
      v1 <= accept;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      addr1  <= in_column;
      pix1   <= pix0;
      res1   <= res0;
      fe1    <= fe0;
      rmask1 <= rmask0;
      cmask1 <= cmask0;
      res2   <= res1;
      fe2    <= fe1;
      rmask2 <= rmask1;
      cmask2 <= cmask1;
    end
  end

  // sliding window: shift left, new column from the line store and input
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 9; k++) win[k] <= '0;
    end else if (adv && v1) begin
      for (int i = 0; i < 3; i++) begin
        win[i*3+0] <= win[i*3+1];
        win[i*3+1] <= win[i*3+2];
      end
      win[2] <= top1;
      win[5] <= mid1;
      win[8] <= pix1;
    end
  end

  // masked maximum: per row, then across rows
  always_comb begin
    logic [PIX_W-1:0] rowmax [3];
    for (int i = 0; i < 3; i++) begin
      rowmax[i] = '0;
      for (int j = 0; j < 3; j++) begin
        if (cmask2[j] && win[i*3+j] > rowmax[i]) rowmax[i] = win[i*3+j];
      end
    end
    max2 = '0;
    for (int i = 0; i < 3; i++) begin
      if (rmask2[i] && rowmax[i] > max2) max2 = rowmax[i];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= v2 && res2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= max2;
      m_tlast <= fe2;
    end
  end

  // checks
  a_out_from_pipe: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(v2 && res2))
    else $error("result appeared without an item in the last stage");

  a_stage_from_transfer: assert property (@(posedge clk) disable iff (rst)
    $rose(v1) |-> $past(s_tvalid && s_tready))
    else $error("stage 1 filled without an input transfer");

  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    (accept && fe0) |=> (in_column == '0 && in_row == '0))
    else $error("position not restarted after frame end");

endmodule
